@@ sv/rsea_pkg.sv @@
// ----------------------------------------------------------------------------
// rsea_pkg
// shared types and codes of the resample and ensemble average core
// ----------------------------------------------------------------------------
package rsea_pkg;

    localparam int S_TDATA_W = 176;
    localparam int M_TDATA_W = 280;
    localparam int CFG_DATA_W = 32;

    localparam logic [1:0] REQ_SAMPLE = 2'd0;
    localparam logic [1:0] REQ_END_RUN = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

    localparam logic [1:0] CFG_TIME_STEP = 2'd0;
    localparam logic [1:0] CFG_MAX_STEP = 2'd1;
    localparam logic [1:0] CFG_ERRORS_ENABLE = 2'd2;
    localparam logic [1:0] CFG_CONDITION_ALIVE = 2'd3;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_GT,
        ST_CHECK,
        ST_FRAC,
        ST_MUL,
        ST_RND,
        ST_SQ,
        ST_ACC,
        ST_FILL,
        ST_RADDR,
        ST_RDATA,
        ST_STAT,
        ST_OUT
    } ctrl_state_t;

    typedef enum logic [3:0] {
        LOP_NONE,
        LOP_SET_PRIOR,
        LOP_LOAD_CUR,
        LOP_LOAD_PRIOR,
        LOP_MUL,
        LOP_RND,
        LOP_SQUARE,
        LOP_ACC,
        LOP_CLEAR,
        LOP_STAT
    } lane_op_t;

    typedef enum logic [2:0] {
        LP_IDLE,
        LP_DIV,
        LP_CAP,
        LP_MUL2,
        LP_VAR,
        LP_SQRT
    } lane_phase_t;

    typedef struct packed {
        lane_op_t    op;
        logic [15:0] frac;
        logic        errors;
    } lane_cmd_t;

    typedef struct packed {
        logic        busy;
        logic [31:0] mean;
        logic [30:0] spread;
    } lane_stat_t;

endpackage

@@ sv/rsea_frac_div.sv @@
// ----------------------------------------------------------------------------
// rsea_frac_div
// restoring divider for the q0.16 interpolation fraction, one bit per cycle
// ----------------------------------------------------------------------------
module rsea_frac_div
    import rsea_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic        busy,
    output logic [15:0] frac
);

    logic        busy_reg;
    logic [3:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [31:0] den_reg;
    logic [15:0] quo_reg;
    logic [32:0] rem_sh;
    logic        take;

    assign rem_sh = {rem_reg, 1'b0};
    assign take = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 4'd1;
            if (&cnt_reg) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num;
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= take ? 32'(rem_sh - {1'b0, den_reg}) : rem_sh[31:0];
            quo_reg <= {quo_reg[14:0], take};
        end
    end

    assign busy = busy_reg;
    assign frac = quo_reg;

endmodule

@@ sv/rsea_lane.sv @@
// ----------------------------------------------------------------------------
// rsea_lane
// one column: interpolation, accumulator memories and mean / deviation unit
// ----------------------------------------------------------------------------
module rsea_lane
    import rsea_pkg::*;
#(
    parameter int GRID_POINTS = 1024,
    parameter int COUNT_BITS = 16,
    localparam int GA = $clog2(GRID_POINTS)
)(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  lane_cmd_t             cmd,
    input  logic [GA-1:0]         addr,
    input  logic [31:0]           cur,
    input  logic [COUNT_BITS-1:0] n,
    output lane_stat_t            stat
);

    logic signed [47:0] sum_mem [GRID_POINTS];
    logic        [63:0] sq_mem  [GRID_POINTS];
    logic signed [47:0] sum_rd_reg;
    logic        [63:0] sq_rd_reg;

    logic [31:0]        prior_reg;
    logic [31:0]        v_reg;
    logic signed [49:0] p_reg;
    logic [63:0]        sq_reg;

    lane_phase_t phase_reg, phase_next;
    logic [5:0]            cnt_reg;
    logic                  neg_reg;
    logic                  err_reg;
    logic [COUNT_BITS-1:0] dn_reg;
    logic [63:0]           dvd_m_reg, dvd_s_reg;
    logic [COUNT_BITS-1:0] rem_m_reg, rem_s_reg;
    logic [31:0]           am_reg, mean_reg;
    logic [63:0]           m2_reg, x_reg, r_reg, bit_reg;
    logic [30:0]           spread_reg;

    // interpolation
    logic signed [32:0] d33;
    logic signed [49:0] d_ext, f_ext;
    logic        [49:0] pmag, pq;
    logic        [31:0] qv, v_int, vmag;
    assign d33 = $signed({cur[31], cur}) - $signed({prior_reg[31], prior_reg});
    assign d_ext = 50'(d33);
    assign f_ext = $signed({34'd0, cmd.frac});
    assign pmag = p_reg[49] ? 50'(-p_reg) : 50'(p_reg);
    assign pq = (pmag + 50'd32768) >> 16;
    assign qv = pq[31:0];
    assign v_int = prior_reg + (p_reg[49] ? 32'(-qv) : qv);
    assign vmag = v_reg[31] ? 32'(-v_reg) : v_reg;

    // accumulate
    logic signed [48:0] s49;
    logic signed [47:0] sum_sat;
    logic        [64:0] t65;
    logic        [63:0] sq_sat;
    assign s49 = {sum_rd_reg[47], sum_rd_reg} + 49'($signed(v_reg));
    assign sum_sat = (s49[48] != s49[47]) ? (s49[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}})
                                           : s49[47:0];
    assign t65 = {1'b0, sq_rd_reg} + {1'b0, sq_reg};
    assign sq_sat = t65[64] ? {64{1'b1}} : t65[63:0];

    always_ff @(posedge aclk) begin
        if (cmd.op == LOP_CLEAR) begin
            sum_mem[addr] <= '0;
            sq_mem[addr] <= '0;
        end else if (cmd.op == LOP_ACC) begin
            sum_mem[addr] <= sum_sat;
            if (cmd.errors) begin
                sq_mem[addr] <= sq_sat;
            end
        end
        sum_rd_reg <= sum_mem[addr];
        sq_rd_reg <= sq_mem[addr];
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            LOP_SET_PRIOR:  prior_reg <= cur;
            LOP_LOAD_CUR:   v_reg <= cur;
            LOP_LOAD_PRIOR: v_reg <= prior_reg;
            LOP_MUL:        p_reg <= d_ext * f_ext;
            LOP_RND:        v_reg <= v_int;
            LOP_SQUARE:     sq_reg <= 64'(vmag) * 64'(vmag);
            default:        ;
        endcase
    end

    // mean and deviation
    logic [47:0]           smag;
    logic [COUNT_BITS:0]   rsh_m, rsh_s;
    logic                  take_m, take_s;
    logic [63:0]           qcap;
    logic [31:0]           am;
    logic [63:0]           rb;
    logic                  sq_take;
    assign smag = sum_rd_reg[47] ? 48'(-sum_rd_reg) : 48'(sum_rd_reg);
    assign rsh_m = {rem_m_reg, dvd_m_reg[63]};
    assign rsh_s = {rem_s_reg, dvd_s_reg[63]};
    assign take_m = rsh_m >= {1'b0, dn_reg};
    assign take_s = rsh_s >= {1'b0, dn_reg};
    assign qcap = dvd_m_reg;
    assign am = neg_reg ? ((qcap > 64'h8000_0000) ? 32'h8000_0000 : qcap[31:0])
                        : ((qcap > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : qcap[31:0]);
    assign rb = r_reg + bit_reg;
    assign sq_take = x_reg >= rb;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= LP_IDLE;
        end else begin
            phase_reg <= phase_next;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            LP_IDLE: if (cmd.op == LOP_STAT) phase_next = LP_DIV;
            LP_DIV:  if (&cnt_reg) phase_next = LP_CAP;
            LP_CAP:  phase_next = LP_MUL2;
            LP_MUL2: phase_next = LP_VAR;
            LP_VAR:  phase_next = LP_SQRT;
            LP_SQRT: if (&cnt_reg[4:0]) phase_next = LP_IDLE;
            default: phase_next = LP_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        case (phase_reg)
            LP_IDLE: begin
                if (cmd.op == LOP_STAT) begin
                    neg_reg <= sum_rd_reg[47];
                    err_reg <= cmd.errors;
                    dn_reg <= n;
                    dvd_m_reg <= 64'(smag) + 64'(n >> 1);
                    dvd_s_reg <= sq_rd_reg;
                    rem_m_reg <= '0;
                    rem_s_reg <= '0;
                    cnt_reg <= '0;
                end
            end
            LP_DIV: begin
                cnt_reg <= cnt_reg + 6'd1;
                rem_m_reg <= take_m ? COUNT_BITS'(rsh_m - {1'b0, dn_reg})
                                    : rsh_m[COUNT_BITS-1:0];
                rem_s_reg <= take_s ? COUNT_BITS'(rsh_s - {1'b0, dn_reg})
                                    : rsh_s[COUNT_BITS-1:0];
                dvd_m_reg <= {dvd_m_reg[62:0], take_m};
                dvd_s_reg <= {dvd_s_reg[62:0], take_s};
            end
            LP_CAP: begin
                am_reg <= am;
                mean_reg <= neg_reg ? 32'(-am) : am;
            end
            LP_MUL2: m2_reg <= 64'(am_reg) * 64'(am_reg);
            LP_VAR: begin
                x_reg <= (dvd_s_reg > m2_reg) ? dvd_s_reg - m2_reg : 64'd0;
                r_reg <= '0;
                bit_reg <= 64'd1 << 62;
                cnt_reg <= '0;
            end
            LP_SQRT: begin
                cnt_reg <= cnt_reg + 6'd1;
                bit_reg <= bit_reg >> 2;
                if (sq_take) begin
                    x_reg <= x_reg - rb;
                    r_reg <= (r_reg >> 1) + bit_reg;
                end else begin
                    r_reg <= r_reg >> 1;
                end
                if (&cnt_reg[4:0]) begin
                    if (!err_reg) begin
                        spread_reg <= '0;
                    end else if (sq_take) begin
                        spread_reg <= (((r_reg >> 1) + bit_reg) > 64'h7FFF_FFFF) ?
                            31'h7FFF_FFFF : 31'((r_reg >> 1) + bit_reg);
                    end else begin
                        spread_reg <= ((r_reg >> 1) > 64'h7FFF_FFFF) ?
                            31'h7FFF_FFFF : 31'(r_reg >> 1);
                    end
                end
            end
            default: ;
        endcase
    end

    assign stat.busy = phase_reg != LP_IDLE;
    assign stat.mean = mean_reg;
    assign stat.spread = spread_reg;

endmodule

@@ sv/resample_and_ensemble_average_core.sv @@
// ----------------------------------------------------------------------------
// resample_and_ensemble_average_core
// resamples runs onto a uniform grid and reports per-point mean and deviation
// ----------------------------------------------------------------------------
// channel   direction  contents
// s_        in         sample, end of run, read and clear requests
// m_        out        per grid point run count, means and deviations
// cfg_wr_   in         register writes
//
// one request at a time; a sample takes each grid point it reaches through
// ST_GT, ST_CHECK, ST_SQ and ST_ACC, an interpolated one also through the
// serial fraction divider, ST_MUL and ST_RND; end of run takes each filled
// point through ST_FILL, ST_SQ and ST_ACC; a read waits on the 64-step lane
// divider and 32-step square root; reset and a clear request sweep the store
// a waiting result does not stop the next request from being accepted
// ----------------------------------------------------------------------------
module resample_and_ensemble_average_core
    import rsea_pkg::*;
#(
    parameter int GRID_POINTS = 1024,
    parameter int COLUMNS = 4,
    parameter int COUNT_BITS = 16
)(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // sample_time, value_a, value_b, value_c, value_d, grid_index
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // req_type
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // read_step, run_count, mean_a..mean_d, spread_a..spread_d
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_wr_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    localparam int GA = $clog2(GRID_POINTS);
    localparam int NGW = GA + 1;
    localparam int LW = (NGW > 10) ? NGW : 10;
    localparam int GTW = NGW + 32;

    logic [31:0] time_step_reg;
    logic [9:0]  max_step_reg;
    logic        errors_reg, alive_reg;

    ctrl_state_t state_reg, state_next;
    logic [31:0]           time_reg;
    logic [31:0]           cur_reg [4];
    logic [9:0]            gidx_reg;
    logic [NGW-1:0]        next_g_reg;
    logic                  awaiting_reg;
    logic [31:0]           prior_time_reg;
    logic [GTW-1:0]        gt_reg;
    logic                  fill_mode_reg, fill_go_reg;
    logic [GA-1:0]         clr_addr_reg;
    logic [COUNT_BITS-1:0] n_reg;
    logic                  zero_reg;

    logic [COUNT_BITS-1:0] cnt_mem [GRID_POINTS];
    logic [COUNT_BITS-1:0] cnt_rd_reg;

    logic                  m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]  m_data_reg, m_data_next;

    lane_cmd_t       cmd;
    lane_stat_t      stat [4];
    logic [GA-1:0]   addr;
    logic            cnt_we;
    logic [COUNT_BITS-1:0] cnt_wdata;
    logic            frac_start, frac_busy;
    logic [31:0]     frac_num;
    logic [15:0]     frac;
    logic            accept;
    logic            lanes_busy;

    logic [LW-1:0]   last_pt, next_ext, gidx_ext;
    logic            past_last;
    logic [GTW-1:0]  time_ext, prior_ext;
    logic            out_of_store;
    logic [31:0]     n_wide;

    assign accept = s_tvalid && s_tready;
    assign last_pt = (LW'(max_step_reg) < LW'(GRID_POINTS - 1)) ? LW'(max_step_reg)
                                                                  : LW'(GRID_POINTS - 1);
    assign next_ext = LW'(next_g_reg);
    assign past_last = next_ext > last_pt;
    assign time_ext = GTW'(time_reg);
    assign prior_ext = GTW'(prior_time_reg);
    assign gidx_ext = LW'(s_tdata[169:160]);
    assign out_of_store = gidx_ext >= LW'(GRID_POINTS);
    assign n_wide = 32'(n_reg);

    always_comb begin
        lanes_busy = 1'b0;
        for (int c = 0; c < 4; c++) begin
            lanes_busy = lanes_busy | stat[c].busy;
        end
    end

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_step_reg <= 32'd65536;
            max_step_reg <= 10'd1023;
            errors_reg <= 1'b0;
            alive_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_TIME_STEP:       time_step_reg <= cfg_wr_data;
                CFG_MAX_STEP:        max_step_reg <= cfg_wr_data[9:0];
                CFG_ERRORS_ENABLE:   errors_reg <= cfg_wr_data[0];
                CFG_CONDITION_ALIVE: alive_reg <= cfg_wr_data[0];
                default:             ;
            endcase
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        s_tready = 1'b0;
        cmd.op = LOP_NONE;
        cmd.frac = frac;
        cmd.errors = errors_reg;
        addr = GA'(next_g_reg);
        cnt_we = 1'b0;
        cnt_wdata = (&cnt_rd_reg) ? cnt_rd_reg : cnt_rd_reg + 1'b1;
        frac_start = 1'b0;
        frac_num = (gt_reg > prior_ext) ? gt_reg[31:0] - prior_time_reg : 32'd0;
        case (state_reg)
            ST_CLEAR: begin
                addr = clr_addr_reg;
                cmd.op = LOP_CLEAR;
                cnt_we = 1'b1;
                cnt_wdata = '0;
                if (clr_addr_reg == GA'(GRID_POINTS - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (accept) begin
                    case (s_tuser)
                        REQ_SAMPLE:  state_next = ST_START;
                        REQ_END_RUN: state_next = ST_FILL;
                        REQ_READ:    state_next = out_of_store ? ST_OUT : ST_RADDR;
                        REQ_CLEAR:   state_next = ST_CLEAR;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_START: begin
                if (past_last) begin
                    state_next = ST_IDLE;
                end else begin
                    if (awaiting_reg) cmd.op = LOP_SET_PRIOR;
                    state_next = ST_GT;
                end
            end
            ST_GT: state_next = ST_CHECK;
            ST_CHECK: begin
                if (past_last || time_ext < gt_reg) begin
                    cmd.op = LOP_SET_PRIOR;
                    state_next = ST_IDLE;
                end else if (time_ext == gt_reg || time_reg <= prior_time_reg) begin
                    cmd.op = LOP_LOAD_CUR;
                    state_next = ST_SQ;
                end else begin
                    frac_start = 1'b1;
                    state_next = ST_FRAC;
                end
            end
            ST_FRAC: if (!frac_busy) state_next = ST_MUL;
            ST_MUL: begin
                cmd.op = LOP_MUL;
                state_next = ST_RND;
            end
            ST_RND: begin
                cmd.op = LOP_RND;
                state_next = ST_SQ;
            end
            ST_SQ: begin
                cmd.op = LOP_SQUARE;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.op = LOP_ACC;
                cnt_we = 1'b1;
                state_next = fill_mode_reg ? ST_FILL : ST_GT;
            end
            ST_FILL: begin
                if (fill_go_reg && !past_last) begin
                    cmd.op = LOP_LOAD_PRIOR;
                    state_next = ST_SQ;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_RADDR: begin
                addr = GA'(gidx_reg);
                state_next = ST_RDATA;
            end
            ST_RDATA: begin
                addr = GA'(gidx_reg);
                if (cnt_rd_reg == '0) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.op = LOP_STAT;
                    state_next = ST_STAT;
                end
            end
            ST_STAT: if (!lanes_busy) state_next = ST_OUT;
            ST_OUT: if (!m_valid_reg || m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_valid_next = (state_reg == ST_OUT) || (m_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_addr_reg <= '0;
            next_g_reg <= '0;
            awaiting_reg <= 1'b1;
            prior_time_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
            case (state_reg)
                ST_CLEAR: clr_addr_reg <= clr_addr_reg + 1'b1;
                ST_IDLE: begin
                    if (accept) begin
                        time_reg <= s_tdata[31:0];
                        cur_reg[0] <= s_tdata[63:32];
                        cur_reg[1] <= s_tdata[95:64];
                        cur_reg[2] <= s_tdata[127:96];
                        cur_reg[3] <= s_tdata[159:128];
                        gidx_reg <= s_tdata[169:160];
                        fill_mode_reg <= s_tuser == REQ_END_RUN;
                        fill_go_reg <= !alive_reg && !awaiting_reg;
                        n_reg <= '0;
                        zero_reg <= 1'b1;
                        clr_addr_reg <= '0;
                        if (s_tuser == REQ_CLEAR) begin
                            next_g_reg <= '0;
                            awaiting_reg <= 1'b1;
                            prior_time_reg <= '0;
                        end
                    end
                end
                ST_START: begin
                    if (!past_last && awaiting_reg) begin
                        prior_time_reg <= time_reg;
                        awaiting_reg <= 1'b0;
                    end
                end
                ST_GT: gt_reg <= GTW'(next_g_reg) * GTW'(time_step_reg);
                ST_CHECK: begin
                    if (past_last || time_ext < gt_reg) prior_time_reg <= time_reg;
                end
                ST_ACC: next_g_reg <= next_g_reg + 1'b1;
                ST_FILL: begin
                    if (!(fill_go_reg && !past_last)) begin
                        next_g_reg <= '0;
                        awaiting_reg <= 1'b1;
                        prior_time_reg <= '0;
                    end
                end
                ST_RDATA: begin
                    n_reg <= cnt_rd_reg;
                    zero_reg <= cnt_rd_reg == '0;
                end
                default: ;
            endcase
        end
    end

    // count store
    always_ff @(posedge aclk) begin
        if (cnt_we) cnt_mem[addr] <= cnt_wdata;
        cnt_rd_reg <= cnt_mem[addr];
    end

    rsea_frac_div u_frac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (frac_start),
        .num     (frac_num),
        .den     (time_reg - prior_time_reg),
        .busy    (frac_busy),
        .frac    (frac)
    );

    for (genvar c = 0; c < 4; c++) begin : g_lane
        if (c < COLUMNS) begin : g_on
            rsea_lane #(
                .GRID_POINTS (GRID_POINTS),
                .COUNT_BITS  (COUNT_BITS)
            ) u_lane (
                .aclk    (aclk),
                .aresetn (aresetn),
                .cmd     (cmd),
                .addr    (addr),
                .cur     (cur_reg[c]),
                .n       (cnt_rd_reg),
                .stat    (stat[c])
            );
        end else begin : g_off
            assign stat[c] = '0;
        end
    end

    // merge lane results into the result register
    always_comb begin
        m_data_next = m_data_reg;
        if (state_reg == ST_OUT && (!m_valid_reg || m_tready)) begin
            m_data_next = '0;
            m_data_next[9:0] = gidx_reg;
            m_data_next[25:10] = (n_wide > 32'hFFFF) ? 16'hFFFF : n_wide[15:0];
            if (!zero_reg) begin
                for (int c = 0; c < 4; c++) begin
                    m_data_next[26 + 32*c +: 32] = stat[c].mean;
                    m_data_next[154 + 31*c +: 31] = stat[c].spread;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;

endmodule

@@ sv/rsea_checker.sv @@
// ----------------------------------------------------------------------------
// rsea_checker
// port-level checks of the resample and ensemble average core
// ----------------------------------------------------------------------------
module rsea_checker
    import rsea_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_sweep: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("request taken during store sweep");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while busy");

    a_empty_point: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[25:10] == 16'd0 |-> m_tdata[277:26] == '0)
        else $error("empty grid point reports nonzero statistics");

endmodule

bind resample_and_ensemble_average_core rsea_checker u_rsea_checker (.*);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the resample and ensemble average core. Runs of
// timestamped samples go through several register settings; an in-bench
// predictor resamples them onto the grid, keeps the per-point sums and
// forecasts every read result, which is compared field by field.
// ----------------------------------------------------------------------------
import rsea_pkg::*;

class grid_scoreboard;
    localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF;
    localparam longint SUM_MIN = -SUM_MAX - 1;

    longint          val_sum [4096];
    bit [63:0]       sq_sum  [4096];
    int unsigned     runs    [1024];
    int unsigned     next_pt;
    bit              want_first;
    bit [31:0]       prev_t;
    int              prev_v  [4];
    bit [31:0]       step_time;
    bit [9:0]        max_step;
    bit              err_en;
    bit              alive;
    bit [M_TDATA_W-1:0] reads_q[$];
    int              mismatches;

    function new();
        wipe();
        step_time = 32'd65536;
        max_step = 10'd1023;
        err_en = 0;
        alive = 0;
        mismatches = 0;
    endfunction

    function void run_restart();
        next_pt = 0;
        want_first = 1;
        prev_t = 0;
        foreach (prev_v[c]) prev_v[c] = 0;
    endfunction

    function void wipe();
        foreach (val_sum[k]) begin
            val_sum[k] = 0;
            sq_sum[k] = 0;
        end
        foreach (runs[g]) runs[g] = 0;
        run_restart();
    endfunction

    function void set_reg(bit [1:0] idx, bit [31:0] val);
        case (idx)
            CFG_TIME_STEP: step_time = val;
            CFG_MAX_STEP: max_step = val[9:0];
            CFG_ERRORS_ENABLE: err_en = val[0];
            CFG_CONDITION_ALIVE: alive = val[0];
            default: ;
        endcase
    endfunction

    function longint rnd_div(longint t, longint unsigned d,
                             longint unsigned cap_p, longint unsigned cap_n);
        bit neg;
        longint unsigned mag, q;
        neg = t < 0;
        mag = neg ? -t : t;
        q = (mag + d / 2) / d;
        if (neg) return (q > cap_n) ? -longint'(cap_n) : -longint'(q);
        return (q > cap_p) ? longint'(cap_p) : longint'(q);
    endfunction

    function longint unsigned sqrt_floor(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function void accumulate(int unsigned g, int v[4]);
        longint s;
        longint unsigned m, sq, t;
        if (runs[g] < 65535) runs[g]++;
        for (int c = 0; c < 4; c++) begin
            s = val_sum[g*4+c] + longint'(v[c]);
            val_sum[g*4+c] = s > SUM_MAX ? SUM_MAX : (s < SUM_MIN ? SUM_MIN : s);
            if (err_en) begin
                m = v[c] < 0 ? -longint'(v[c]) : longint'(v[c]);
                sq = m * m;
                t = sq_sum[g*4+c] + sq;
                sq_sum[g*4+c] = (t < sq) ? 64'hFFFF_FFFF_FFFF_FFFF : t;
            end
        end
    endfunction

    function void sample(bit [31:0] t, int cur[4]);
        int unsigned last;
        longint unsigned gt, num, den;
        longint f, d;
        int v[4];
        last = max_step;
        if (next_pt > last) return;
        if (want_first) begin
            prev_t = t;
            prev_v = cur;
            want_first = 0;
        end
        while (next_pt <= last) begin
            gt = longint'(next_pt) * step_time;
            if (longint'(t) < gt) break;
            if (longint'(t) == gt || t <= prev_t) begin
                v = cur;
            end else begin
                num = gt > prev_t ? gt - prev_t : 0;
                den = longint'(t) - prev_t;
                f = (num << 16) / den;
                for (int c = 0; c < 4; c++) begin
                    d = longint'(cur[c]) - longint'(prev_v[c]);
                    v[c] = int'(longint'(prev_v[c]) + rnd_div(d * f, 65536, '1, '1));
                end
            end
            accumulate(next_pt, v);
            next_pt++;
        end
        prev_t = t;
        prev_v = cur;
    endfunction

    function void note_request(bit [1:0] req, bit [S_TDATA_W-1:0] data);
        int cur[4];
        int unsigned g, n;
        longint m;
        longint unsigned e2, am, m2;
        bit [M_TDATA_W-1:0] res;
        for (int c = 0; c < 4; c++) cur[c] = data[32*(c+1) +: 32];
        case (req)
            REQ_SAMPLE: sample(data[31:0], cur);
            REQ_END_RUN: begin
                if (!alive && !want_first)
                    for (int unsigned p = next_pt; p <= max_step; p++) accumulate(p, prev_v);
                run_restart();
            end
            REQ_CLEAR: wipe();
            default: begin
                g = data[169:160];
                n = runs[g];
                res = '0;
                res[9:0] = g;
                res[25:10] = n;
                if (n != 0) begin
                    for (int c = 0; c < 4; c++) begin
                        m = rnd_div(val_sum[g*4+c], n, 64'h7FFF_FFFF, 64'h8000_0000);
                        res[26+32*c +: 32] = m[31:0];
                        if (err_en) begin
                            e2 = sq_sum[g*4+c] / n;
                            am = m < 0 ? -m : m;
                            m2 = am * am;
                            e2 = sqrt_floor(e2 > m2 ? e2 - m2 : 0);
                            res[154+31*c +: 31] = e2 > 64'h7FFF_FFFF ? 31'h7FFF_FFFF : e2[30:0];
                        end
                    end
                end
                reads_q.insert(reads_q.size(), res);
            end
        endcase
    endfunction

    function void check_result(bit [M_TDATA_W-1:0] got);
        bit [M_TDATA_W-1:0] exp_r;
        int lo[10] = '{0, 10, 26, 58, 90, 122, 154, 185, 216, 247};
        int wd[10] = '{10, 16, 32, 32, 32, 32, 31, 31, 31, 31};
        bit [31:0] e, a;
        if (reads_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected read result %h", got);
            return;
        end
        exp_r = reads_q.pop_front();
        for (int i = 0; i < 10; i++) begin
            e = (exp_r >> lo[i]) & ((64'd1 << wd[i]) - 1);
            a = (got >> lo[i]) & ((64'd1 << wd[i]) - 1);
            if (e !== a) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("read mismatch field %0d step %0d: expected %h got %h",
                             i, exp_r[9:0], e, a);
            end
        end
    endfunction

    function int pending();
        return reads_q.size();
    endfunction
endclass

module tb_top;
    localparam longint CYCLE_LIMIT = 6_000_000;
    localparam int ITEMS = 1550;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_wr_en;
    logic [1:0]            cfg_wr_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;

    grid_scoreboard sb = new();
    longint cycles = 0;
    int sent = 0;
    bit quiet = 0;
    int stall_left = 0;

    resample_and_ensemble_average_core DUT (.*);

    initial aclk = 0;
    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= (stall_left == 1);
        end else if (!quiet && $urandom % 8 == 0) begin
            m_tready <= 0;
            stall_left <= $urandom_range(1, 10);
        end else begin
            m_tready <= 1;
        end
    end

    always @(posedge aclk)
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);

    function automatic bit [31:0] pick_value();
        case ($urandom % 8)
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic bit [S_TDATA_W-1:0] pack(bit [31:0] t, bit [9:0] g);
        bit [S_TDATA_W-1:0] d;
        d = '0;
        d[31:0] = t;
        for (int c = 0; c < 4; c++) d[32*(c+1) +: 32] = pick_value();
        d[169:160] = g;
        return d;
    endfunction

    task automatic send(bit [1:0] req, bit [S_TDATA_W-1:0] data);
        if (!quiet && $urandom % 5 == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser <= req;
        s_tdata <= data;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(req, data);
        sent++;
        quiet = sent > ITEMS - 200;
    endtask

    task automatic read_point(bit [9:0] g);
        send(REQ_READ, pack($urandom, g));
    endtask

    // finish with a read and let the block drain
    task automatic drain();
        read_point($urandom_range(0, sb.max_step));
        s_tvalid <= 0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic cfg_write(bit [1:0] idx, bit [31:0] val);
        cfg_wr_en <= 1;
        cfg_wr_index <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        sb.set_reg(idx, val);
    endtask

    task automatic sample_run(int n);
        longint t, ts;
        ts = sb.step_time;
        t = (longint'($urandom) * ts) >> 31;
        for (int i = 0; i < n; i++) begin
            case ($urandom % 8)
                0: t = t;
                1: t = t - ((longint'($urandom) * ts) >> 32);
                default: t = t + ((longint'($urandom) * ts) >> 30);
            endcase
            if (t < 0) t = 0;
            if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
            send(REQ_SAMPLE, pack(t[31:0], $urandom));
        end
        if ($urandom % 10 != 0) send(REQ_END_RUN, pack($urandom, $urandom));
    endtask

    initial begin
        int budget, ms;
        bit [31:0] ts;
        aresetn <= 0;
        s_tvalid <= 0;
        s_tuser <= REQ_SAMPLE;
        s_tdata <= '0;
        m_tready <= 0;
        cfg_wr_en <= 0;
        cfg_wr_index <= CFG_TIME_STEP;
        cfg_wr_data <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        repeat (1100) @(posedge aclk);

        // directed: empty store, extremes, held times, fill on end, clear
        read_point(0);
        read_point(10'd1023);
        send(REQ_END_RUN, pack(0, 0));
        send(REQ_SAMPLE, {6'd0, 10'd0, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000});
        send(REQ_SAMPLE, {6'd0, 10'd0, 32'h7FFF_FFFF, 32'h8000_0000,
                          32'h0001_0000, 32'hFFFF_0000, 32'h0003_8000});
        send(REQ_SAMPLE, pack(32'h0002_8000, 0));
        send(REQ_SAMPLE, pack(32'h0005_4321, 0));
        send(REQ_END_RUN, pack(0, 0));
        for (int g = 0; g < 6; g++) read_point(g);
        read_point(10'd1023);
        send(REQ_SAMPLE, pack(32'hFFFF_FFFF, 0));
        send(REQ_SAMPLE, pack(32'hFFFF_FFFF, 0));
        read_point(10'd1023);
        send(REQ_CLEAR, pack($urandom, $urandom));
        read_point(3);
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: ts = 32'd1;
                1: ts = 32'hFFFF_FFFF;
                2, 6: ts = 32'd65536;
                3: ts = 32'h0000_8000;
                default: ts = $urandom_range(1, 32'h0004_0000);
            endcase
            case (ph)
                1, 4: ms = 0;
                5: ms = 1023;
                7: ms = 1;
                default: ms = $urandom_range(2, 31);
            endcase
            cfg_write(CFG_TIME_STEP, ts);
            cfg_write(CFG_MAX_STEP, ms);
            cfg_write(CFG_ERRORS_ENABLE, (ph % 3) != 1);
            cfg_write(CFG_CONDITION_ALIVE, (ph % 4) == 3);
            cfg_wr_en <= 0;
            budget = sent + ((ph == 5) ? 50 : 165);
            while (sent < budget) begin
                case ($urandom % 10)
                    0, 1, 2, 3, 4, 5: begin
                        sample_run($urandom_range(1, 6));
                        repeat ($urandom_range(1, 3))
                            read_point($urandom_range(0, ms + 1));
                    end
                    6: send($urandom, pack($urandom, $urandom));
                    7: read_point($urandom);
                    8: send(REQ_END_RUN, pack($urandom, $urandom));
                    default: if ($urandom % 4 == 0) send(REQ_CLEAR, pack($urandom, $urandom));
                endcase
            end
            drain();
        end

        while (sb.pending() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
